// ===== sv/lc3_instruction_execute_defines.svh =====
// assertion helpers for the lc3 core checker
`ifndef LC3_INSTRUCTION_EXECUTE_DEFINES_SVH
`define LC3_INSTRUCTION_EXECUTE_DEFINES_SVH

// checked at every edge out of reset
`define LC3IE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define LC3IE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lc3ie_pkg.sv =====
`timescale 1ns / 1ps
package lc3ie_pkg;

  localparam int MemAddrBits = 16;
  localparam int MemWords = 1 << MemAddrBits;

  typedef logic [15:0] word_t;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_STEP  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_PROT    = 3'd2;
  localparam logic [2:0] ST_RSVD    = 3'd3;
  localparam logic [2:0] ST_BADTRAP = 3'd4;
  localparam logic [2:0] ST_NOTRAP  = 3'd5;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [7:0] TRAP_GETC = 8'h20;
  localparam logic [7:0] TRAP_OUT  = 8'h21;
  localparam logic [7:0] TRAP_IN   = 8'h23;
  localparam logic [7:0] TRAP_HALT = 8'h25;
  localparam logic [7:0] TRAP_LAST = 8'h27;

  localparam word_t IO_KBSR = 16'hFE00;
  localparam word_t IO_KBDR = 16'hFE02;
  localparam word_t IO_DDR  = 16'hFE06;
  localparam word_t IO_MCR  = 16'hFFFE;
  localparam word_t KBSR_READY = 16'h8000;

  localparam logic [1:0] CFG_START_BASE = 2'd0;
  localparam logic [1:0] CFG_PROT_EN    = 2'd1;
  localparam logic [1:0] CFG_PROT_LOW   = 2'd2;
  localparam logic [1:0] CFG_PROT_HIGH  = 2'd3;

  localparam word_t START_BASE_RST = 16'h3000;
  localparam word_t PROT_LOW_RST   = 16'h0000;
  localparam word_t PROT_HIGH_RST  = 16'h2FFF;

  typedef struct packed {
    kind_t       kind;
    word_t       addr;
    word_t       data;
    logic        key_valid;
    logic [7:0]  key_char;
  } item_t;

  // front to back
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // back to front
  typedef struct packed {
    logic pop;
    logic open;
  } back_ctl_t;

  function automatic word_t sx5(word_t v);
    return {{11{v[4]}}, v[4:0]};
  endfunction

  function automatic word_t sx6(word_t v);
    return {{10{v[5]}}, v[5:0]};
  endfunction

  function automatic word_t sx9(word_t v);
    return {{7{v[8]}}, v[8:0]};
  endfunction

  function automatic word_t sx11(word_t v);
    return {{5{v[10]}}, v[10:0]};
  endfunction

  function automatic logic [2:0] nzp(word_t v);
    logic [2:0] f;
    if (v == 16'h0000) f = 3'b010;
    else if (v[15]) f = 3'b100;
    else f = 3'b001;
    return f;
  endfunction

endpackage

// ===== sv/lc3ie_ram.sv =====
`timescale 1ns / 1ps
module lc3ie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lc3ie_front.sv =====
`timescale 1ns / 1ps
module lc3ie_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [1:0]            kind,
  input  logic [15:0]           addr,
  input  logic [15:0]           data,
  input  logic                  key_valid,
  input  logic [7:0]            key_char,
  input  lc3ie_pkg::back_ctl_t  ctl,
  output lc3ie_pkg::queue_head_t head
);

  lc3ie_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign item_stall = (count == 2'd2) || !ctl.open;
  assign push = item_valid && !item_stall;
  assign pop  = ctl.pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= '{kind: lc3ie_pkg::kind_t'(kind), addr: addr, data: data,
                           key_valid: key_valid, key_char: key_char};
        wr_ptr <= !wr_ptr;
      end
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/lc3ie_back.sv =====
`timescale 1ns / 1ps
module lc3ie_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  lc3ie_pkg::queue_head_t head,
  output lc3ie_pkg::back_ctl_t   ctl,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [2:0]             status,
  output logic [15:0]            pc_before,
  output logic [15:0]            instr,
  output logic                   out_valid,
  output logic [7:0]             out_char,
  output logic                   key_taken,
  output logic [2:0]             cond_flags,
  output logic                   is_running
);

  localparam int AW = lc3ie_pkg::MemAddrBits;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_RDW, S_KBDR, S_DEC, S_EXEC,
    S_LDI2, S_LDDONE, S_STI2, S_WR, S_FIN
  } state_t;

  state_t state, rd_ret;

  // configuration
  lc3ie_pkg::word_t start_base, prot_low, prot_high;
  logic prot_en;

  // architectural state
  lc3ie_pkg::word_t pc;
  logic [2:0] cond;
  logic run;
  logic [7:0] rf_valid;

  // per-item working registers
  lc3ie_pkg::word_t rd_addr, rdata, cur_instr, item_pc, wr_addr, wr_data;
  logic cur_key_v;
  logic [7:0] cur_key_c;
  logic [2:0] st_r;
  logic ov_r, kt_r;
  logic [7:0] oc_r;
  logic [AW-1:0] clr_cnt;

  // memory ports
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  lc3ie_pkg::word_t mem_wdata, mem_q;

  // register file ports
  logic rf_we;
  logic [2:0] rf_waddr, ra_addr, rb_addr;
  lc3ie_pkg::word_t rf_wdata, ra_q, rb_q, op_a, op_b, op2, alu;
  logic va, vb;

  lc3ie_pkg::word_t dec_word;
  logic [3:0] opc;
  logic [7:0] vec;
  logic prot_hit, slot_free;

  lc3ie_ram #(.WIDTH(16), .DEPTH(lc3ie_pkg::MemWords)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_q)
  );

  // two copies of the register file, one per read port
  lc3ie_ram #(.WIDTH(16), .DEPTH(8)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(ra_addr), .rdata(ra_q)
  );

  lc3ie_ram #(.WIDTH(16), .DEPTH(8)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rb_addr), .rdata(rb_q)
  );

  assign opc = cur_instr[15:12];
  assign vec = cur_instr[7:0];
  assign dec_word = (state == S_DEC) ? rdata : cur_instr;
  assign ra_addr = dec_word[8:6];
  always_comb begin
    if (dec_word[15:12] == lc3ie_pkg::OP_ST || dec_word[15:12] == lc3ie_pkg::OP_STR ||
        dec_word[15:12] == lc3ie_pkg::OP_STI) begin
      rb_addr = dec_word[11:9];
    end else if (dec_word[15:12] == lc3ie_pkg::OP_TRAP) begin
      rb_addr = 3'd0;
    end else begin
      rb_addr = dec_word[2:0];
    end
  end

  // never-written registers read as zero
  assign op_a = va ? ra_q : '0;
  assign op_b = vb ? rb_q : '0;
  assign op2  = cur_instr[5] ? lc3ie_pkg::sx5(cur_instr) : op_b;

  always_comb begin
    case (opc)
      lc3ie_pkg::OP_ADD: alu = op_a + op2;
      lc3ie_pkg::OP_AND: alu = op_a & op2;
      lc3ie_pkg::OP_NOT: alu = ~op_a;
      default:           alu = pc + lc3ie_pkg::sx9(cur_instr);
    endcase
  end

  assign prot_hit = prot_en && (wr_addr >= prot_low) && (wr_addr <= prot_high);
  assign slot_free = !result_valid || !result_stall;
  assign mem_raddr = rd_addr[AW-1:0];

  assign ctl.open = (state != S_CLR);
  assign ctl.pop  = (state == S_IDLE) && head.valid;

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = wr_addr[AW-1:0];
    mem_wdata = wr_data;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (head.valid && head.item.kind == lc3ie_pkg::KIND_LOAD) begin
          mem_we = 1'b1;
          mem_waddr = head.item.addr[AW-1:0];
          mem_wdata = head.item.data;
        end
      end
      S_RD: begin
        if (rd_addr == lc3ie_pkg::IO_KBSR) begin
          mem_we = 1'b1;
          mem_waddr = lc3ie_pkg::IO_KBSR[AW-1:0];
          mem_wdata = cur_key_v ? lc3ie_pkg::KBSR_READY : '0;
        end
      end
      S_KBDR: begin
        mem_we = 1'b1;
        mem_waddr = lc3ie_pkg::IO_KBDR[AW-1:0];
        mem_wdata = {8'h00, cur_key_c};
      end
      S_WR: begin
        mem_we = !prot_hit && (wr_addr != lc3ie_pkg::IO_DDR) &&
                 (wr_addr != lc3ie_pkg::IO_MCR);
      end
      default: ;
    endcase
  end

  always_comb begin
    rf_we = 1'b0;
    rf_waddr = cur_instr[11:9];
    rf_wdata = alu;
    if (state == S_EXEC) begin
      case (opc)
        lc3ie_pkg::OP_ADD, lc3ie_pkg::OP_AND, lc3ie_pkg::OP_NOT, lc3ie_pkg::OP_LEA:
          rf_we = 1'b1;
        lc3ie_pkg::OP_JSR: begin
          rf_we = 1'b1;
          rf_waddr = 3'd7;
          rf_wdata = pc;
        end
        lc3ie_pkg::OP_TRAP: begin
          if ((vec == lc3ie_pkg::TRAP_GETC || vec == lc3ie_pkg::TRAP_IN) && cur_key_v) begin
            rf_we = 1'b1;
            rf_waddr = 3'd0;
            rf_wdata = {8'h00, cur_key_c};
          end
        end
        default: ;
      endcase
    end else if (state == S_LDDONE) begin
      rf_we = 1'b1;
      rf_wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      rd_ret <= S_DEC;
      clr_cnt <= '0;
      start_base <= lc3ie_pkg::START_BASE_RST;
      prot_en <= 1'b1;
      prot_low <= lc3ie_pkg::PROT_LOW_RST;
      prot_high <= lc3ie_pkg::PROT_HIGH_RST;
      pc <= '0;
      cond <= '0;
      run <= 1'b1;
      rf_valid <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lc3ie_pkg::CFG_START_BASE: start_base <= cfg_data;
          lc3ie_pkg::CFG_PROT_EN:    prot_en <= cfg_data[0];
          lc3ie_pkg::CFG_PROT_LOW:   prot_low <= cfg_data;
          lc3ie_pkg::CFG_PROT_HIGH:  prot_high <= cfg_data;
          default: ;
        endcase
      end
      if (rf_we) rf_valid[rf_waddr] <= 1'b1;
      if (state == S_FIN && slot_free) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;

      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) state <= S_IDLE;
        end
        S_IDLE: begin
          if (head.valid) begin
            cur_key_v <= head.item.key_valid;
            cur_key_c <= head.item.key_char;
            cur_instr <= '0;
            ov_r <= 1'b0;
            oc_r <= '0;
            kt_r <= 1'b0;
            unique case (head.item.kind)
              lc3ie_pkg::KIND_START: begin
                pc <= start_base + head.item.data;
                item_pc <= start_base + head.item.data;
                run <= 1'b1;
                st_r <= lc3ie_pkg::ST_OK;
                state <= S_FIN;
              end
              lc3ie_pkg::KIND_STEP: begin
                item_pc <= pc;
                if (!run) begin
                  st_r <= lc3ie_pkg::ST_HALT;
                  state <= S_FIN;
                end else begin
                  st_r <= lc3ie_pkg::ST_OK;
                  rd_addr <= pc;
                  rd_ret <= S_DEC;
                  state <= S_RD;
                end
              end
              default: begin
                item_pc <= pc;
                st_r <= lc3ie_pkg::ST_OK;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_RD: begin
          if (rd_addr == lc3ie_pkg::IO_KBSR) begin
            rdata <= cur_key_v ? lc3ie_pkg::KBSR_READY : '0;
            if (cur_key_v) begin
              kt_r <= 1'b1;
              state <= S_KBDR;
            end else begin
              state <= rd_ret;
            end
          end else begin
            state <= S_RDW;
          end
        end
        S_RDW: begin
          rdata <= mem_q;
          state <= rd_ret;
        end
        S_KBDR: state <= rd_ret;
        S_DEC: begin
          cur_instr <= rdata;
          pc <= item_pc + 16'd1;
          state <= S_EXEC;
        end
        S_EXEC: begin
          wr_data <= op_b;
          unique case (opc)
            lc3ie_pkg::OP_BR: begin
              if (|(cond & cur_instr[11:9])) pc <= pc + lc3ie_pkg::sx9(cur_instr);
              state <= S_FIN;
            end
            lc3ie_pkg::OP_ADD, lc3ie_pkg::OP_AND, lc3ie_pkg::OP_NOT, lc3ie_pkg::OP_LEA: begin
              cond <= lc3ie_pkg::nzp(alu);
              state <= S_FIN;
            end
            lc3ie_pkg::OP_LD: begin
              rd_addr <= pc + lc3ie_pkg::sx9(cur_instr);
              rd_ret <= S_LDDONE;
              state <= S_RD;
            end
            lc3ie_pkg::OP_LDR: begin
              rd_addr <= op_a + lc3ie_pkg::sx6(cur_instr);
              rd_ret <= S_LDDONE;
              state <= S_RD;
            end
            lc3ie_pkg::OP_LDI: begin
              rd_addr <= pc + lc3ie_pkg::sx9(cur_instr);
              rd_ret <= S_LDI2;
              state <= S_RD;
            end
            lc3ie_pkg::OP_ST: begin
              wr_addr <= pc + lc3ie_pkg::sx9(cur_instr);
              state <= S_WR;
            end
            lc3ie_pkg::OP_STR: begin
              wr_addr <= op_a + lc3ie_pkg::sx6(cur_instr);
              state <= S_WR;
            end
            lc3ie_pkg::OP_STI: begin
              rd_addr <= pc + lc3ie_pkg::sx9(cur_instr);
              rd_ret <= S_STI2;
              state <= S_RD;
            end
            lc3ie_pkg::OP_JSR: begin
              pc <= cur_instr[11] ? pc + lc3ie_pkg::sx11(cur_instr) : op_a;
              state <= S_FIN;
            end
            lc3ie_pkg::OP_JMP: begin
              pc <= op_a;
              state <= S_FIN;
            end
            lc3ie_pkg::OP_TRAP: begin
              state <= S_FIN;
              if (vec < lc3ie_pkg::TRAP_GETC || vec > lc3ie_pkg::TRAP_LAST) begin
                st_r <= lc3ie_pkg::ST_BADTRAP;
              end else begin
                case (vec)
                  lc3ie_pkg::TRAP_GETC, lc3ie_pkg::TRAP_IN: begin
                    // no key yet: rerun the trap on the next step
                    if (!cur_key_v) begin
                      pc <= item_pc;
                    end else begin
                      kt_r <= 1'b1;
                      if (vec == lc3ie_pkg::TRAP_IN) begin
                        ov_r <= 1'b1;
                        oc_r <= cur_key_c;
                      end
                    end
                  end
                  lc3ie_pkg::TRAP_OUT: begin
                    ov_r <= 1'b1;
                    oc_r <= op_b[7:0];
                  end
                  lc3ie_pkg::TRAP_HALT: begin
                    run <= 1'b0;
                    st_r <= lc3ie_pkg::ST_HALT;
                  end
                  default: st_r <= lc3ie_pkg::ST_NOTRAP;
                endcase
              end
            end
            default: begin
              st_r <= lc3ie_pkg::ST_RSVD;
              state <= S_FIN;
            end
          endcase
        end
        S_LDI2: begin
          rd_addr <= rdata;
          rd_ret <= S_LDDONE;
          state <= S_RD;
        end
        S_LDDONE: begin
          cond <= lc3ie_pkg::nzp(rdata);
          state <= S_FIN;
        end
        S_STI2: begin
          wr_addr <= rdata;
          state <= S_WR;
        end
        S_WR: begin
          if (prot_hit) begin
            st_r <= lc3ie_pkg::ST_PROT;
          end else if (wr_addr == lc3ie_pkg::IO_DDR) begin
            ov_r <= 1'b1;
            oc_r <= wr_data[7:0];
          end else if (wr_addr == lc3ie_pkg::IO_MCR && !wr_data[15]) begin
            run <= 1'b0;
            st_r <= lc3ie_pkg::ST_HALT;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            status <= st_r;
            pc_before <= item_pc;
            instr <= cur_instr;
            out_valid <= ov_r;
            out_char <= oc_r;
            key_taken <= kt_r;
            cond_flags <= cond;
            is_running <= run;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    va <= rf_valid[ra_addr];
    vb <= rf_valid[rb_addr];
  end

endmodule

// ===== sv/lc3_instruction_execute.sv =====
// requests execute one at a time: the next is taken from the queue only after the
// previous result is registered; a word memory read passes states S_RD and S_RDW,
// a kbsr read without a key returns from S_RD alone
// a two-entry request queue and an output register decouple both handshakes
// reset clears registers, then sweeps every word memory location to zero;
// requests are stalled during the sweep, configuration writes are taken
`timescale 1ns / 1ps
module lc3_instruction_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] addr,
  input  logic [15:0] data,
  input  logic        key_valid,
  input  logic [7:0]  key_char,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [15:0] pc_before,
  output logic [15:0] instr,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        key_taken,
  output logic [2:0]  cond_flags,
  output logic        is_running
);

  lc3ie_pkg::queue_head_t head;
  lc3ie_pkg::back_ctl_t   ctl;

  assign cfg_ready = 1'b1;

  lc3ie_front u_front (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .addr(addr), .data(data),
    .key_valid(key_valid), .key_char(key_char),
    .ctl(ctl), .head(head)
  );

  lc3ie_back u_back (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .head(head), .ctl(ctl),
    .result_valid(result_valid), .result_stall(result_stall),
    .status(status), .pc_before(pc_before), .instr(instr),
    .out_valid(out_valid), .out_char(out_char), .key_taken(key_taken),
    .cond_flags(cond_flags), .is_running(is_running)
  );

endmodule

// ===== sv/lc3ie_checker.sv =====
`timescale 1ns / 1ps
`include "lc3_instruction_execute_defines.svh"
module lc3ie_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  status,
  input logic        out_valid,
  input logic [7:0]  out_char,
  input logic [2:0]  cond_flags,
  input logic        is_running
);

  `LC3IE_ASSERT(a_res_hold, result_valid && result_stall |=> result_valid, "result dropped while stalled")
  `LC3IE_ASSERT(a_halt_stops, result_valid && status == lc3ie_pkg::ST_HALT |-> !is_running, "halt status with core running")
  `LC3IE_ASSERT(a_char_zero, result_valid && !out_valid |-> out_char == 8'h00, "character without display write")
  `LC3IE_ASSERT(a_flags, result_valid |-> $onehot0(cond_flags), "condition flags not one-hot")
  `LC3IE_ASSERT_ALWAYS(a_prot_no_out, result_valid && status == lc3ie_pkg::ST_PROT |-> !out_valid, "dropped write reached display")

endmodule

bind lc3_instruction_execute lc3ie_checker u_lc3ie_checker (
  .clk(clk), .rst(rst), .result_valid(result_valid), .result_stall(result_stall),
  .status(status), .out_valid(out_valid), .out_char(out_char),
  .cond_flags(cond_flags), .is_running(is_running)
);
